// ----- rtl/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types and constants of the cubic Bezier easing evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int MAX_ITER_DEF  = 100;
  localparam int TOL_LSB_DEF   = 4;

  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = 4;

  localparam logic [2:0] REG_START_X    = 3'd0;
  localparam logic [2:0] REG_START_Y    = 3'd1;
  localparam logic [2:0] REG_END_X      = 3'd2;
  localparam logic [2:0] REG_END_Y      = 3'd3;
  localparam logic [2:0] REG_HANDLE_A_X = 3'd4;
  localparam logic [2:0] REG_HANDLE_A_Y = 3'd5;
  localparam logic [2:0] REG_HANDLE_B_X = 3'd6;
  localparam logic [2:0] REG_HANDLE_B_Y = 3'd7;

  localparam logic REQ_POINT = 1'b0;
  localparam logic REQ_SOLVE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [15:0] operand_value;
  } in_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] final_param;
    logic [6:0]         iterations_used;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GUESS,
    S_LOAD,
    S_STEP,
    S_NDIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_CX,
    PH_DX,
    PH_FX,
    PH_FY
  } phase_t;

endpackage

// ----- rtl/cubic_bezier_easing_eval.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_easing_eval
// Cubic Bezier easing: point at a parameter, or y for a given x by Newton steps.
// ----------------------------------------------------------------------------
// Point request: x and then y are evaluated at the parameter, then out_valid strobes.
// Solve request: an endpoint shortcut goes straight to the strobe; otherwise a divider
// guess (none when end x is zero), then Newton passes of x, derivative and divide
// (no divide when the derivative is flat), then x and y at the final parameter.
// One transaction at a time; busy is high until the strobe. The receiver
// cannot stall. Synchronous reset loads the default curve registers.
module cubic_bezier_easing_eval #(
  parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITER  = cbe_pkg::MAX_ITER_DEF,
  parameter int TOL_LSB   = cbe_pkg::TOL_LSB_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  cbe_pkg::in_t                in_data,
  output logic                        out_valid,
  output cbe_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [cbe_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [15:0]                 cfg_wdata
);
  import cbe_pkg::*;

  localparam int PW    = 20;
  localparam int TW    = 17;
  localparam int NUM_W = 18 + FRAC_BITS;
  localparam int QW    = NUM_W + 1;
  localparam int SW    = QW + 1;
  localparam int IW    = $clog2(MAX_ITER + 1);
  localparam int ONE   = 1 << FRAC_BITS;
  localparam logic signed [15:0] ONE_SAT = (ONE > 32767) ? 16'sd32767 : 16'(ONE);
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-32768);
  localparam logic signed [PW-1:0] TOL_P  = PW'(TOL_LSB);
  localparam logic signed [QW-1:0] TOL_Q  = QW'(TOL_LSB);
  localparam logic signed [17:0]   TOL_E  = 18'(TOL_LSB);

  logic signed [15:0] cfg_r [NUM_REGS];

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic [2:0] k_r, k_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic signed [15:0] t_r, t_nxt, opv_r, opv_nxt;
  logic signed [15:0] px_r, px_nxt, py_r, py_nxt, fp_r, fp_nxt;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  logic signed [PW-1:0] cx_r, cx_nxt;

  logic signed [TW-1:0] tc;
  logic signed [PW-1:0] la, lb, ly;
  logic [1:0] pair;
  logic accept, sc_start, sc_end, ex_zero, step_last, dx_flat, step_small, iter_max;
  logic div_start, div_done;
  logic signed [NUM_W-1:0] div_num;
  logic signed [PW-1:0] div_den;
  logic signed [QW-1:0] quot;
  logic signed [SW-1:0] t_sub;
  logic signed [17:0] opv_e;

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    if (v > SAT_HI) return 16'sh7fff;
    if (v < SAT_LO) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_START_X]    <= '0;
      cfg_r[REG_START_Y]    <= '0;
      cfg_r[REG_END_X]      <= ONE_SAT;
      cfg_r[REG_END_Y]      <= ONE_SAT;
      cfg_r[REG_HANDLE_A_X] <= '0;
      cfg_r[REG_HANDLE_A_Y] <= '0;
      cfg_r[REG_HANDLE_B_X] <= ONE_SAT;
      cfg_r[REG_HANDLE_B_Y] <= ONE_SAT;
    end else if (cfg_we && (int'(cfg_addr) < NUM_REGS)) begin
      cfg_r[cfg_addr[2:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    if (t_r < 0) begin
      tc = '0;
    end else if (int'(t_r) > ONE) begin
      tc = TW'(ONE);
    end else begin
      tc = TW'(t_r);
    end
  end

  always_comb begin
    if (phase_r == PH_DX) begin
      unique case (k_r)
        3'd0:    pair = 2'd0;
        3'd1:    pair = 2'd1;
        default: pair = 2'd0;
      endcase
    end else begin
      unique case (k_r)
        3'd0, 3'd3, 3'd5: pair = 2'd0;
        3'd1, 3'd4:       pair = 2'd1;
        default:          pair = 2'd2;
      endcase
    end
  end

  always_comb begin
    unique case (pair)
      2'd0: begin la = p0_r; lb = p1_r; end
      2'd1: begin la = p1_r; lb = p2_r; end
      default: begin la = p2_r; lb = p3_r; end
    endcase
  end

  cbe_lerp #(.FRAC_BITS(FRAC_BITS), .PW(PW), .TW(TW)) u_lerp (
    .a(la), .b(lb), .t(tc), .y(ly)
  );

  assign opv_e      = 18'(in_data.operand_value);
  assign accept     = start && !busy;
  assign sc_start   = opv_e <= (18'(cfg_r[REG_START_X]) + TOL_E);
  assign sc_end     = opv_e >= (18'(cfg_r[REG_END_X]) - TOL_E);
  assign ex_zero    = cfg_r[REG_END_X] == 16'sd0;
  assign step_last  = (phase_r == PH_DX) ? (k_r == 3'd2) : (k_r == 3'd5);
  assign dx_flat    = (ly <= TOL_P) && (ly >= -TOL_P);
  assign step_small = (quot <= TOL_Q) && (quot >= -TOL_Q);
  assign iter_max   = iter_r == IW'(MAX_ITER);
  assign t_sub      = SW'(t_r) - SW'(quot);

  always_comb begin
    if (state_r == S_IDLE) begin
      div_num = NUM_W'(in_data.operand_value) <<< FRAC_BITS;
      div_den = PW'(cfg_r[REG_END_X]);
    end else begin
      div_num = (NUM_W'(cx_r) - NUM_W'(opv_r)) <<< FRAC_BITS;
      div_den = ly;
    end
  end

  cbe_div #(.NUM_W(NUM_W), .DEN_W(PW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_POINT) state_nxt = S_LOAD;
          else if (sc_start || sc_end)       state_nxt = S_DONE;
          else if (ex_zero)                  state_nxt = S_LOAD;
          else                               state_nxt = S_GUESS;
        end
      end
      S_GUESS: if (div_done) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_STEP;
      S_STEP: begin
        if (step_last) begin
          if (phase_r == PH_FY)                  state_nxt = S_DONE;
          else if (phase_r == PH_DX && !dx_flat) state_nxt = S_NDIV;
          else                                   state_nxt = S_LOAD;
        end
      end
      S_NDIV:  if (div_done) state_nxt = S_LOAD;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    k_nxt     = k_r;
    iter_nxt  = iter_r;
    t_nxt     = t_r;
    opv_nxt   = opv_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    fp_nxt    = fp_r;
    cx_nxt    = cx_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    p3_nxt    = p3_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          opv_nxt  = in_data.operand_value;
          iter_nxt = '0;
          t_nxt    = in_data.operand_value;
          if (in_data.req_type == REQ_POINT) begin
            phase_nxt = PH_FX;
          end else if (sc_start) begin
            px_nxt = cfg_r[REG_START_X];
            py_nxt = cfg_r[REG_START_Y];
            fp_nxt = '0;
          end else if (sc_end) begin
            px_nxt = cfg_r[REG_END_X];
            py_nxt = cfg_r[REG_END_Y];
            fp_nxt = ONE_SAT;
          end else if (ex_zero) begin
            phase_nxt = PH_CX;
            t_nxt = in_data.operand_value[15] ? 16'sh8000 :
                    (in_data.operand_value == 16'sd0) ? 16'sd0 : 16'sh7fff;
          end else begin
            phase_nxt = PH_CX;
            div_start = 1'b1;
          end
        end
      end
      S_GUESS: begin
        if (div_done) t_nxt = sat16(SW'(quot));
      end
      S_LOAD: begin
        k_nxt = '0;
        unique case (phase_r)
          PH_FY: begin
            p0_nxt = PW'(cfg_r[REG_START_Y]);
            p1_nxt = PW'(cfg_r[REG_HANDLE_A_Y]);
            p2_nxt = PW'(cfg_r[REG_HANDLE_B_Y]);
            p3_nxt = PW'(cfg_r[REG_END_Y]);
          end
          PH_DX: begin
            p0_nxt = PW'(3) * (PW'(cfg_r[REG_HANDLE_A_X]) - PW'(cfg_r[REG_START_X]));
            p1_nxt = PW'(3) * (PW'(cfg_r[REG_HANDLE_B_X]) - PW'(cfg_r[REG_HANDLE_A_X]));
            p2_nxt = PW'(3) * (PW'(cfg_r[REG_END_X]) - PW'(cfg_r[REG_HANDLE_B_X]));
          end
          default: begin
            if (phase_r == PH_FX) fp_nxt = tc[15:0];
            p0_nxt = PW'(cfg_r[REG_START_X]);
            p1_nxt = PW'(cfg_r[REG_HANDLE_A_X]);
            p2_nxt = PW'(cfg_r[REG_HANDLE_B_X]);
            p3_nxt = PW'(cfg_r[REG_END_X]);
          end
        endcase
      end
      S_STEP: begin
        k_nxt = k_r + 3'd1;
        unique case (pair)
          2'd0:    p0_nxt = ly;
          2'd1:    p1_nxt = ly;
          default: p2_nxt = ly;
        endcase
        if (step_last) begin
          unique case (phase_r)
            PH_CX: begin
              cx_nxt    = ly;
              iter_nxt  = iter_r + IW'(1);
              phase_nxt = PH_DX;
            end
            PH_DX: begin
              if (dx_flat) phase_nxt = PH_FX;
              else         div_start = 1'b1;
            end
            PH_FX: begin
              px_nxt    = ly[15:0];
              phase_nxt = PH_FY;
            end
            default: py_nxt = ly[15:0];
          endcase
        end
      end
      S_NDIV: begin
        if (div_done) begin
          t_nxt     = sat16(t_sub);
          phase_nxt = (step_small || iter_max) ? PH_FX : PH_CX;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_CX;
      k_r     <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      iter_r  <= iter_nxt;
    end
    t_r   <= t_nxt;
    opv_r <= opv_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    fp_r  <= fp_nxt;
    cx_r  <= cx_nxt;
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    p3_r  <= p3_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;
  assign out_data.point_x         = px_r;
  assign out_data.point_y         = py_r;
  assign out_data.final_param     = fp_r;
  assign out_data.iterations_used = (int'(iter_r) > 127) ? 7'd127 : 7'(iter_r);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("accepted transaction did not raise busy");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (int'(iter_r) <= MAX_ITER)) else $error("iteration count overran");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_GUESS || state_r == S_NDIV))
    else $error("divider finished outside a divide wait");

endmodule

// ----- rtl/cbe_lerp.sv -----
// ----------------------------------------------------------------------------
// cbe_lerp
// Shared interpolation unit: a + round((b - a) * t / one).
// ----------------------------------------------------------------------------
module cbe_lerp #(
  parameter int FRAC_BITS = 12,
  parameter int PW        = 20,
  parameter int TW        = 17
) (
  input  logic signed [PW-1:0] a,
  input  logic signed [PW-1:0] b,
  input  logic signed [TW-1:0] t,
  output logic signed [PW-1:0] y
);
  localparam int MW   = PW + 1 + TW;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  logic signed [MW-1:0] ae;
  logic signed [MW-1:0] diff;
  logic signed [MW-1:0] prod;
  logic signed [MW-1:0] rnd;
  logic signed [MW-1:0] sum;

  assign ae   = MW'(a);
  assign diff = MW'(b) - ae;
  assign prod = diff * MW'(t);
  assign rnd  = prod + MW'(HALF);
  assign sum  = ae + (rnd >>> FRAC_BITS);
  assign y    = sum[PW-1:0];

endmodule

// ----- rtl/cbe_div.sv -----
// ----------------------------------------------------------------------------
// cbe_div
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module cbe_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                   done,
  output logic signed [NUM_W:0]  quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic             run_r, run_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0] qn_r, qn_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_r[DEN_W-1:0], qn_r[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    qn_nxt   = qn_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(NUM_W);
      qn_nxt  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      den_nxt = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      rem_nxt = '0;
      neg_nxt = num[NUM_W-1] ^ den[DEN_W-1];
    end else if (run_r) begin
      rem_nxt = fits ? rem_sh - {1'b0, den_r} : rem_sh;
      qn_nxt  = {qn_r[NUM_W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    qn_r  <= qn_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});

endmodule
